/* design/pss_pkg.sv */
// Shared types and constants of the pattern step sequencer.
`timescale 1ns / 1ps

package pss_pkg;

  localparam int PATTERN_STEPS_DEF = 16;
  localparam int MIN_TICK          = 64;
  localparam int MAX_LEN           = 4032;
  localparam int SPT_RESET         = 6000;
  localparam int PHASE_W           = 16;
  localparam int NOTE_W            = 7;
  localparam int INST_W            = 8;
  localparam int STEP_W            = NOTE_W + INST_W;

  typedef enum logic [1:0] {
    KIND_ADVANCE = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_PLAY    = 2'd2,
    KIND_STOP    = 2'd3
  } kind_e;

  typedef struct packed {
    logic               start;
    logic [PHASE_W-1:0] num;
    logic [PHASE_W-1:0] den;
  } rem_req_t;

  typedef struct packed {
    logic               done;
    logic [PHASE_W-1:0] rem;
  } rem_rsp_t;

endpackage

/* design/pss_ram.sv */
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps

module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/pss_rem.sv */
// Bit-serial remainder unit for phase reduction, one quotient bit per cycle.
`timescale 1ns / 1ps

module pss_rem
  import pss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  localparam int CW = $clog2(PHASE_W);

  logic               busy_q, done_q;
  logic [CW-1:0]      cnt_q;
  logic [PHASE_W-1:0] num_q, den_q, rem_q;
  logic [PHASE_W:0]   trial;
  logic               ge;
  logic [PHASE_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, num_q[PHASE_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? PHASE_W'(trial - {1'b0, den_q}) : trial[PHASE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(PHASE_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[PHASE_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* design/pattern_step_sequencer_core.sv */
// Top level of the pattern step sequencer: control, step store and result register.
//
//  channel  dir  handshake                  payload
//  cfg      in   cfg_valid_i / cfg_ready_o  cfg_samples_per_tick_i
//  in       in   in_valid_i / in_ready_o    in_kind_i, in_length_i, in_step_index_i,
//                                           in_note_i, in_instrument_i
//  out      out  out_valid_o / out_ready_i  out_event_valid_o .. out_last_o
//
// Write, play, stop and an idle advance (stopped or zero length) go straight to the status beat.
// An advance while playing walks F boundaries (at most 63): a serial phase remainder
// first, then a step-store read and an emit state for each boundary, then the status beat.
// One item is in work at a time; in_ready_o is high in idle.
// Reset clears the step store at once through per-step valid bits; no clearing pass.
// A stalled output holds the sequencer at its next beat to send until the beat is taken.
`timescale 1ns / 1ps

module pattern_step_sequencer_core
  import pss_pkg::*;
#(
  parameter int PATTERN_STEPS = PATTERN_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_samples_per_tick_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_kind_i,
  input  logic [11:0]        in_length_i,
  input  logic [3:0]         in_step_index_i,
  input  logic [NOTE_W-1:0]  in_note_i,
  input  logic [INST_W-1:0]  in_instrument_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_event_valid_o,
  output logic [11:0]        out_hold_offset_o,
  output logic [NOTE_W-1:0]  out_event_note_o,
  output logic [INST_W-1:0]  out_event_instrument_o,
  output logic [3:0]         out_position_o,
  output logic               out_playing_o,
  output logic               out_last_o
);

  localparam int PW   = $clog2(PATTERN_STEPS);
  localparam int PCW  = PW + 1;
  localparam int CMPW = PW + 5;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MOD    = 5'b00010,
    S_NEXT   = 5'b00100,
    S_EMIT   = 5'b01000,
    S_STATUS = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic                play_q, play_d;
  logic [15:0]         spt_q;
  logic [PHASE_W-1:0]  spt_eff_q, spt_eff_d, spt_eff;
  logic [11:0]         len_q, len_d, len_clamp;
  logic [PHASE_W:0]    hold_q, hold_d, phase_end;
  logic [11:0]         off_q, off_d;
  logic                zfire_q, zfire_d;

  logic                out_valid_q, ev_q, oplay_q, last_q;
  logic [11:0]         ooff_q;
  logic [NOTE_W-1:0]   onote_q;
  logic [INST_W-1:0]   oinst_q;
  logic [3:0]          opos_q;
  logic                out_free, ld_event, ld_status;

  logic [PATTERN_STEPS-1:0] vld_q;
  logic                vld_rd_q;
  logic                ram_we, ram_re;
  logic [PW-1:0]       waddr;
  logic [STEP_W-1:0]   rdata;
  logic [NOTE_W-1:0]   rd_note;
  logic [INST_W-1:0]   rd_inst;
  logic                in_range;
  logic [3:0]          play_r;
  logic [PCW-1:0]      pos_inc;
  logic [PW-1:0]       pos_wrap;
  logic                in_fire;
  rem_req_t            rem_req;
  rem_rsp_t            rem_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign spt_eff   = (spt_q < 16'(MIN_TICK)) ? 16'(MIN_TICK) : spt_q;
  assign len_clamp = (in_length_i > 12'(MAX_LEN)) ? 12'(MAX_LEN) : in_length_i;
  assign in_range  = CMPW'(in_step_index_i) < CMPW'(PATTERN_STEPS);
  assign waddr     = PW'(in_step_index_i);
  assign pos_inc   = {1'b0, pos_q} + 1'b1;
  assign pos_wrap  = (pos_inc == PCW'(PATTERN_STEPS)) ? '0 : pos_inc[PW-1:0];
  assign phase_end = {5'b0, len_q} + {1'b0, spt_eff_q} - hold_q;
  assign rd_note   = vld_rd_q ? rdata[STEP_W-1:INST_W] : '0;
  assign rd_inst   = vld_rd_q ? rdata[INST_W-1:0] : '0;

  // Start position modulo the pattern length by repeated subtraction.
  always_comb begin
    play_r = in_step_index_i;
    for (int i = 0; i < 8; i++) begin
      if (CMPW'(play_r) >= CMPW'(PATTERN_STEPS)) begin
        play_r = 4'(CMPW'(play_r) - CMPW'(PATTERN_STEPS));
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    phase_d     = phase_q;
    play_d      = play_q;
    spt_eff_d   = spt_eff_q;
    len_d       = len_q;
    hold_d      = hold_q;
    off_d       = off_q;
    zfire_d     = zfire_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ld_event    = 1'b0;
    ld_status   = 1'b0;
    rem_req     = '{start: 1'b0, num: phase_q, den: spt_eff};
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_STATUS;
          unique case (kind_e'(in_kind_i))
            KIND_ADVANCE: begin
              if (play_q && (in_length_i != '0)) begin
                rem_req.start = 1'b1;
                spt_eff_d     = spt_eff;
                len_d         = len_clamp;
                state_d       = S_MOD;
              end
            end
            KIND_WRITE: ram_we = in_range;
            KIND_PLAY: begin
              pos_d  = PW'(play_r);
              play_d = 1'b1;
            end
            KIND_STOP: play_d = 1'b0;
            default: ;
          endcase
        end
      end
      S_MOD: begin
        if (rem_rsp.done) begin
          phase_d = rem_rsp.rem;
          zfire_d = (rem_rsp.rem == '0);
          hold_d  = {1'b0, spt_eff_q} - {1'b0, rem_rsp.rem};
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (zfire_q) begin
          zfire_d = 1'b0;
          off_d   = '0;
          ram_re  = 1'b1;
          state_d = S_EMIT;
        end else if (hold_q < {5'b0, len_q}) begin
          off_d   = hold_q[11:0];
          hold_d  = hold_q + {1'b0, spt_eff_q};
          ram_re  = 1'b1;
          state_d = S_EMIT;
        end else begin
          // A boundary exactly at the block end leaves the phase at zero.
          phase_d = (hold_q == {5'b0, len_q}) ? '0 : phase_end[PHASE_W-1:0];
          state_d = S_STATUS;
        end
      end
      S_EMIT: begin
        if ((rd_note == '0) || out_free) begin
          ld_event = (rd_note != '0);
          pos_d    = pos_wrap;
          state_d  = S_NEXT;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          ld_status = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      phase_q     <= '0;
      play_q      <= 1'b0;
      spt_q       <= 16'(SPT_RESET);
      zfire_q     <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      play_q  <= play_d;
      zfire_q <= zfire_d;
      if (cfg_valid_i && cfg_ready_o) begin
        spt_q <= cfg_samples_per_tick_i;
      end
      if (ram_we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (ld_event || ld_status) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    spt_eff_q <= spt_eff_d;
    len_q     <= len_d;
    hold_q    <= hold_d;
    off_q     <= off_d;
    if (ram_re) begin
      vld_rd_q <= vld_q[pos_q];
    end
    if (ld_event) begin
      ev_q    <= 1'b1;
      ooff_q  <= off_q;
      onote_q <= rd_note;
      oinst_q <= rd_inst;
      opos_q  <= 4'(pos_q);
      oplay_q <= 1'b1;
      last_q  <= 1'b0;
    end else if (ld_status) begin
      ev_q    <= 1'b0;
      ooff_q  <= '0;
      onote_q <= '0;
      oinst_q <= '0;
      opos_q  <= 4'(pos_q);
      oplay_q <= play_q;
      last_q  <= 1'b1;
    end
  end

  pss_ram #(
    .WIDTH (STEP_W),
    .DEPTH (PATTERN_STEPS)
  ) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({in_note_i, in_instrument_i}),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  pss_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign out_valid_o            = out_valid_q;
  assign out_event_valid_o      = ev_q;
  assign out_hold_offset_o      = ooff_q;
  assign out_event_note_o       = onote_q;
  assign out_event_instrument_o = oinst_q;
  assign out_position_o         = opos_q;
  assign out_playing_o          = oplay_q;
  assign out_last_o             = last_q;

endmodule

/* design/pss_checker.sv */
// Port-level checker for the pattern step sequencer, bound to the top level.
`timescale 1ns / 1ps

module pss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        out_event_valid_o,
  input logic [11:0] out_hold_offset_o,
  input logic [6:0]  out_event_note_o,
  input logic [7:0]  out_event_instrument_o,
  input logic [3:0]  out_position_o,
  input logic        out_playing_o,
  input logic        out_last_o
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_last_o)
      && $stable(out_position_o) && $stable(out_hold_offset_o)
      && $stable(out_event_note_o))
    else $error("result beat changed while stalled");

  // Every accepted beat owes a status beat, so the input side must close.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted beat");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o |-> !out_event_valid_o && (out_hold_offset_o == 12'd0)
      && (out_event_note_o == 7'd0) && (out_event_instrument_o == 8'd0))
    else $error("status beat carries event fields");

  a_event_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_event_valid_o |-> !out_last_o && out_playing_o
      && (out_event_note_o != 7'd0))
    else $error("malformed event beat");

endmodule

bind pattern_step_sequencer_core pss_checker u_pss_checker (.*);
